@@ rtl/pa_pkg.sv @@
// shared types, constants and fixed-point helpers of the polynomial atan2 core
package pa_pkg;

	localparam int QBITS = 30;
	localparam int VW    = 34;

	typedef logic signed [VW-1:0] val_t;

	typedef struct packed {
		logic zero;
		logic swap;
		logic eq;
		logic xneg;
		logic yneg;
	} ctrl_t;

	localparam val_t C_A1      = val_t'(64'sd1073717407);
	localparam val_t C_A3      = val_t'(-64'sd357151731);
	localparam val_t C_A5      = val_t'(64'sd207815708);
	localparam val_t C_A7      = val_t'(-64'sd125018842);
	localparam val_t C_A9      = val_t'(64'sd56536072);
	localparam val_t C_A11     = val_t'(-64'sd12585543);
	localparam val_t HALF_PI_Q = val_t'(64'sd1686629713);
	localparam val_t PI_Q      = val_t'(64'sd3373259426);
	localparam val_t ONE_Q     = val_t'(64'sd1073741824);

	// q1.30 product, rounded to nearest with ties up
	function automatic val_t mulq(input val_t a, input val_t b);
		logic signed [2*VW-1:0] p;
		p = a * b + (2*VW)'(64'sd536870912);
		return val_t'(p >>> QBITS);
	endfunction

	// horner coefficient added in multiply stage j
	function automatic val_t coef_sel(input int j);
		case (j)
			1: return C_A9;
			2: return C_A7;
			3: return C_A5;
			4: return C_A3;
			5: return C_A1;
			default: return '0;
		endcase
	endfunction

endpackage

@@ rtl/pa_div_cell.sv @@
// one restoring-division cell: produces one quotient bit per stage
module pa_div_cell #(
	parameter int MW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  pa_pkg::ctrl_t   ctrl_in,
	input  logic [MW-1:0]   rem_in,
	input  logic [MW-1:0]   large_in,
	input  logic [30:0]     q_in,
	output logic            valid_s1,
	output pa_pkg::ctrl_t   ctrl_s1,
	output logic [MW-1:0]   rem_s1,
	output logic [MW-1:0]   large_s1,
	output logic [30:0]     q_s1
);
	import pa_pkg::*;

	logic [MW:0] rem2;
	logic [MW:0] diff;
	logic        take;

	// compare doubled remainder against divisor
	always_comb begin
		rem2 = {rem_in, 1'b0};
		diff = rem2 - {1'b0, large_in};
		take = rem2 >= {1'b0, large_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1  <= ctrl_in;
			large_s1 <= large_in;
			rem_s1   <= take ? diff[MW-1:0] : rem2[MW-1:0];
			q_s1     <= {q_in[29:0], take};
		end
	end

endmodule

@@ rtl/pa_mac_cell.sv @@
// one polynomial cell: coef + a*b in q1.30, registered
module pa_mac_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  pa_pkg::ctrl_t ctrl_in,
	input  pa_pkg::val_t  r_in,
	input  pa_pkg::val_t  s_in,
	input  pa_pkg::val_t  a_in,
	input  pa_pkg::val_t  b_in,
	input  pa_pkg::val_t  coef,
	output logic          valid_s1,
	output pa_pkg::ctrl_t ctrl_s1,
	output pa_pkg::val_t  r_s1,
	output pa_pkg::val_t  s_s1,
	output pa_pkg::val_t  res_s1
);
	import pa_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// multiply-add step of the horner chain
	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= ctrl_in;
			r_s1    <= r_in;
			s_s1    <= s_in;
			res_s1  <= val_t'(coef + mulq(a_in, b_in));
		end
	end

endmodule

@@ rtl/polynomial_atan2_core.sv @@
// top level of the pipelined polynomial atan2 core
// Takes one (y, x) pair per cycle and returns atan2(y, x) in signed
// Q2.ANGLE_FRAC_BITS radians, saturated to +-pi. The pipeline holds
// one input stage, 30 division cells (one quotient bit each), seven
// multiply cells for the 11th-order polynomial and one output stage. A
// stall on the output freezes the whole pipeline, which holds the pending
// result steady; otherwise a new pair is taken every cycle.
module polynomial_atan2_core #(
	parameter int COORD_WIDTH     = 32,
	parameter int ANGLE_FRAC_BITS = 29
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [COORD_WIDTH-1:0]  y_coord,
	input  logic signed [COORD_WIDTH-1:0]  x_coord,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [ANGLE_FRAC_BITS+2:0] angle
);
	import pa_pkg::*;

	localparam int MW    = COORD_WIDTH;
	localparam int AW    = ANGLE_FRAC_BITS + 3;
	localparam int OW    = 72;
	localparam int NDIV  = QBITS;
	localparam int NMAC  = 7;

	function automatic logic signed [OW-1:0] to_out(input logic signed [OW-1:0] v);
		if (ANGLE_FRAC_BITS < QBITS)
			return (v + (OW'(1) <<< (QBITS - ANGLE_FRAC_BITS - 1)))
				>>> (QBITS - ANGLE_FRAC_BITS);
		return v <<< (ANGLE_FRAC_BITS - QBITS);
	endfunction

	localparam logic signed [OW-1:0] LIM = to_out(OW'(PI_Q));

	logic en;

	// global advance: freeze only when the output beat is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// input stage: magnitudes, ordering and special-case flags
	logic [MW-1:0] ymag, xmag;
	ctrl_t         ctrl_c;

	always_comb begin
		ymag        = y_coord[MW-1] ? (~y_coord + 1'b1) : y_coord;
		xmag        = x_coord[MW-1] ? (~x_coord + 1'b1) : x_coord;
		ctrl_c.yneg = y_coord[MW-1];
		ctrl_c.xneg = x_coord[MW-1];
		ctrl_c.swap = xmag < ymag;
		ctrl_c.eq   = xmag == ymag;
		ctrl_c.zero = (xmag == '0) && (ymag == '0);
	end

	logic          dv   [0:NDIV];
	ctrl_t         dc   [0:NDIV];
	logic [MW-1:0] drem [0:NDIV];
	logic [MW-1:0] dlg  [0:NDIV];
	logic [30:0]   dq   [0:NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (en) begin
			dv[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc[0]   <= ctrl_c;
			drem[0] <= ctrl_c.swap ? xmag : ymag;
			dlg[0]  <= ctrl_c.swap ? ymag : xmag;
			dq[0]   <= '0;
		end
	end

	// division chain
	for (genvar i = 0; i < NDIV; i++) begin : g_div
		pa_div_cell #(.MW(MW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(dv[i]), .ctrl_in(dc[i]), .rem_in(drem[i]),
			.large_in(dlg[i]), .q_in(dq[i]),
			.valid_s1(dv[i+1]), .ctrl_s1(dc[i+1]), .rem_s1(drem[i+1]),
			.large_s1(dlg[i+1]), .q_s1(dq[i+1])
		);
	end

	logic  mv   [0:NMAC];
	ctrl_t mc   [0:NMAC];
	val_t  mr   [0:NMAC];
	val_t  ms   [0:NMAC];
	val_t  mres [0:NMAC];

	// ratio: exactly one when the magnitudes match
	assign mv[0]   = dv[NDIV];
	assign mc[0]   = dc[NDIV];
	assign mr[0]   = dc[NDIV].eq ? ONE_Q : val_t'({1'b0, dq[NDIV]});
	assign ms[0]   = '0;
	assign mres[0] = '0;

	// polynomial chain: square, five horner steps, final multiply by r
	for (genvar j = 0; j < NMAC; j++) begin : g_mac
		val_t s_use, a_use, b_use;
		always_comb begin
			s_use = (j == 1) ? mres[j] : ms[j];
			a_use = (j == 0 || j == NMAC - 1) ? mr[j] : s_use;
			b_use = (j == 0) ? mr[j] : ((j == 1) ? C_A11 : mres[j]);
		end
		pa_mac_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(mv[j]), .ctrl_in(mc[j]), .r_in(mr[j]), .s_in(s_use),
			.a_in(a_use), .b_in(b_use), .coef(coef_sel(j)),
			.valid_s1(mv[j+1]), .ctrl_s1(mc[j+1]), .r_s1(mr[j+1]),
			.s_s1(ms[j+1]), .res_s1(mres[j+1])
		);
	end

	// quadrant fixup, scaling and saturation
	logic signed [VW+1:0] pp, res;
	logic signed [OW-1:0] scaled, sat;
	logic                 neg;
	ctrl_t                fc;

	always_comb begin
		fc  = mc[NMAC];
		neg = fc.xneg ^ fc.yneg;
		pp  = neg ? -(VW+2)'(mres[NMAC]) : (VW+2)'(mres[NMAC]);
		if (fc.swap)
			res = (neg ? -(VW+2)'(HALF_PI_Q) : (VW+2)'(HALF_PI_Q)) - pp;
		else
			res = pp;
		if (fc.xneg)
			res = res + (fc.yneg ? -(VW+2)'(PI_Q) : (VW+2)'(PI_Q));
		if (fc.zero)
			res = '0;
		scaled = to_out(OW'(res));
		if (scaled > LIM)
			sat = LIM;
		else if (scaled < -LIM)
			sat = -LIM;
		else
			sat = scaled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= mv[NMAC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= sat[AW-1:0];
		end
	end

	// result stays within plus or minus pi
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (OW'(angle) <= LIM) && (OW'(angle) >= -LIM))
		else $error("angle out of range");

	// unequal magnitudes give a ratio below one
	a_ratio_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		(dv[NDIV] && !dc[NDIV].eq) |-> (dq[NDIV][30] == 1'b0))
		else $error("ratio reached one");

	// both coordinates zero yields a zero angle
	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(en && mv[NMAC] && mc[NMAC].zero) |=> (angle == '0))
		else $error("zero input gave nonzero angle");

endmodule
